>>> design/wflr_pkg.sv
// Shared types and constants for the windowed frame loss rate block.
`default_nettype none

package wflr_pkg;

  localparam int CNT_W  = 31;             // frame counters
  localparam int TS_W   = 64;             // millisecond timestamps
  localparam int WIN_W  = 22;             // window register
  localparam int LOSS_W = 15;             // Q.8 percent result
  localparam int SRC_W  = 2;              // rate source code
  localparam int PROD_W = CNT_W + LOSS_W; // num * 25600

  localparam logic [LOSS_W-1:0] FULL_Q8    = 15'd25600;
  localparam logic [WIN_W-1:0]  WINDOW_RST = 22'd30000;
  localparam logic              OP_CLEAR   = 1'b1;

  typedef enum logic [SRC_W-1:0] {
    SRC_NONE = 2'd0,
    SRC_CUM  = 2'd1,
    SRC_WIN  = 2'd2
  } rate_src_t;

  typedef struct packed {
    logic [CNT_W-1:0] dropped;
    logic [CNT_W-1:0] total;
    logic [TS_W-1:0]  tstamp;
  } ring_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_RD,
    ST_NEW_CHK,
    ST_WRITE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_STEP,
    DV_DONE
  } div_state_t;

endpackage

`default_nettype wire

>>> design/windowed_frame_loss_rate_top.sv
// Top level: sample ring in one memory, expiry walk and windowed loss ratio.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_wr_en              cfg_wr_data (window_ms)
//   in       in         in_valid / in_stall    in_opcode, in_dropped_count,
//                                              in_total_count, in_time_ms
//   out      out        out_valid / out_stall  out_loss_percent, out_rate_source
//
// One item at a time. A clear (opcode or zero total) goes from the accept
// cycle straight to the output step. A sample first reads the newest entry
// (skipped when the ring was empty) to catch a backwards total, then writes
// itself, then walks the expiry checks unless the ring now holds one entry:
// each expiry check is a read of the ring memory (one registered read port)
// followed by a compare, and the ratio runs on the serial divider, which stops early when it saturates.
// Reset is synchronous, active low; it empties the ring by clearing the
// oldest pointer and the entry count, no sweep of the memory is needed.
// A result waiting under out_stall holds the block in its last step; the
// next input transfer is taken as soon as that result moves to out_valid.
`default_nettype none

module windowed_frame_loss_rate_top #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wflr_pkg::WIN_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [wflr_pkg::CNT_W-1:0]    in_dropped_count,
  input  wire logic [wflr_pkg::CNT_W-1:0]    in_total_count,
  input  wire logic [wflr_pkg::TS_W-1:0]     in_time_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wflr_pkg::LOSS_W-1:0]        out_loss_percent,
  output logic [wflr_pkg::SRC_W-1:0]         out_rate_source
);
  import wflr_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NUM_W = $clog2(RING_DEPTH + 1);

  // (base + off) mod RING_DEPTH, both operands below RING_DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [NUM_W-1:0] off);
    logic [NUM_W:0] sum;
    sum = (NUM_W+1)'(base) + (NUM_W+1)'(off);
    if (sum >= (NUM_W+1)'(RING_DEPTH)) sum = sum - (NUM_W+1)'(RING_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  // control state
  ctl_state_t        state_r, state_nxt;
  logic [WIN_W-1:0]  window_r;
  logic [IDX_W-1:0]  oldest_r;
  logic [NUM_W-1:0]  count_r;
  logic              out_valid_r;

  // sample under work and ratio operands
  logic [CNT_W-1:0]  drop_r;
  logic [CNT_W-1:0]  total_r;
  logic [TS_W-1:0]   now_r;
  logic [CNT_W-1:0]  num_r;
  logic [CNT_W-1:0]  den_r;
  rate_src_t         src_r;
  logic [LOSS_W-1:0] res_loss_r;
  rate_src_t         res_src_r;
  logic [LOSS_W-1:0] out_loss_r;
  rate_src_t         out_src_r;

  // ring memory
  ring_entry_t       ring_mem [RING_DEPTH];
  ring_entry_t       rd_data_r;
  ring_entry_t       wr_entry;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              mem_rd;
  logic              mem_we;

  logic              accept;
  logic              is_clear;
  logic              out_free;
  logic              ring_full;
  logic [IDX_W-1:0]  oldest_inc;
  logic [IDX_W-1:0]  eff_oldest;
  logic [NUM_W-1:0]  eff_count;
  logic [TS_W-1:0]   age;
  logic              multi;
  logic              expire;
  logic              drop_back;
  logic              win_ok;
  logic              div_start;
  logic              div_done;
  logic [LOSS_W-1:0] div_q;

  assign accept   = in_valid && !in_stall;
  assign is_clear = (in_opcode == OP_CLEAR) || (in_total_count == '0);
  assign out_free = !out_valid_r || !out_stall;

  // a full ring drops its oldest entry to make room for the new one
  assign ring_full  = count_r == NUM_W'(RING_DEPTH);
  assign oldest_inc = slot_of(oldest_r, NUM_W'(1));
  assign eff_oldest = ring_full ? oldest_inc : oldest_r;
  assign eff_count  = ring_full ? NUM_W'(RING_DEPTH - 1) : count_r;
  assign wr_addr    = slot_of(eff_oldest, eff_count);
  assign wr_entry   = '{dropped: drop_r, total: total_r, tstamp: now_r};

  // checks against the oldest entry, valid in ST_EXP_CHK
  assign age       = now_r - rd_data_r.tstamp;
  assign multi     = count_r > NUM_W'(1);
  assign expire    = multi && (age > TS_W'(window_r));
  assign drop_back = multi && !expire && (drop_r < rd_data_r.dropped);
  assign win_ok    = multi && !expire && (drop_r >= rd_data_r.dropped) &&
                     (total_r > rd_data_r.total);

  wflr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (num_r),
    .den      (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_clear) state_nxt = ST_OUT;
          else if (count_r != '0) state_nxt = ST_NEW_RD;
          else state_nxt = ST_WRITE;
        end
      end
      ST_NEW_RD:   state_nxt = ST_NEW_CHK;
      ST_NEW_CHK:  state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = (eff_count == '0) ? ST_DIV_GO : ST_EXP_RD;
      ST_EXP_RD:   state_nxt = ST_EXP_CHK;
      ST_EXP_CHK:  state_nxt = expire ? ST_EXP_RD : ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = oldest_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_NEW_RD: begin
        mem_rd  = 1'b1;
        rd_addr = slot_of(oldest_r, count_r - NUM_W'(1));
      end
      ST_WRITE:  mem_we = 1'b1;
      ST_EXP_RD: mem_rd = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      default:   ;
    endcase
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[wr_addr] <= wr_entry;
    if (mem_rd) rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RST;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) window_r <= cfg_wr_data;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && is_clear) begin
            oldest_r <= '0;
            count_r  <= '0;
          end
        end
        ST_NEW_CHK: begin
          // total went backwards: start over
          if (rd_data_r.total > total_r) begin
            oldest_r <= '0;
            count_r  <= '0;
          end
        end
        ST_WRITE: begin
          oldest_r <= eff_oldest;
          count_r  <= eff_count + NUM_W'(1);
        end
        ST_EXP_CHK: begin
          if (expire) begin
            oldest_r <= oldest_inc;
            count_r  <= count_r - NUM_W'(1);
          end else if (drop_back) begin
            oldest_r <= '0;
            count_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          drop_r     <= in_dropped_count;
          total_r    <= in_total_count;
          now_r      <= in_time_ms;
          res_loss_r <= '0;
          res_src_r  <= SRC_NONE;
        end
      end
      ST_WRITE: begin
        num_r <= drop_r;
        den_r <= total_r;
        src_r <= SRC_CUM;
      end
      ST_EXP_CHK: begin
        if (win_ok) begin
          num_r <= drop_r - rd_data_r.dropped;
          den_r <= total_r - rd_data_r.total;
          src_r <= SRC_WIN;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_loss_r <= div_q;
          res_src_r  <= src_r;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_loss_r <= res_loss_r;
          out_src_r  <= res_src_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_loss_percent = out_loss_r;
  assign out_rate_source  = out_src_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NUM_W'(RING_DEPTH))
    else $error("entry count above ring depth");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, oldest_r} < (IDX_W+1)'(RING_DEPTH))
    else $error("oldest pointer outside ring");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second transfer taken while an item is in work");

  a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_loss_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_loss_percent <= FULL_Q8)
    else $error("loss above 100 percent");
`endif

endmodule

`default_nettype wire

>>> design/wflr_div.sv
// Ratio unit: min(num * 25600 / den, 25600), restoring division one bit per cycle.
`default_nettype none

module wflr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [wflr_pkg::CNT_W-1:0]    num,
  input  wire logic [wflr_pkg::CNT_W-1:0]    den,
  output logic                               done,
  output logic [wflr_pkg::LOSS_W-1:0]        quotient
);
  import wflr_pkg::*;

  localparam int STEP_N  = LOSS_W;
  localparam int STEP_CW = $clog2(STEP_N);

  div_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   den_r;
  logic [LOSS_W-1:0]  low_r;
  logic               sat_r;
  logic [STEP_CW-1:0] step_r;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_diff;
  logic               take;
  logic               last_step;

  // num < den keeps the quotient below 25600, so the top 31 product bits
  // are already a valid partial remainder; only 15 quotient bits remain.
  assign prod      = PROD_W'(num) * PROD_W'(FULL_Q8);
  assign rem_sh    = {rem_r, low_r[LOSS_W-1]};
  assign take      = rem_sh >= {1'b0, den_r};
  assign rem_diff  = rem_sh - {1'b0, den_r};
  assign last_step = step_r == STEP_CW'(STEP_N - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = DV_STEP;
      DV_STEP: if (sat_r || last_step) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    done     = state_r == DV_DONE;
    quotient = sat_r ? FULL_Q8 : low_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      rem_r  <= prod[PROD_W-1:LOSS_W];
      low_r  <= prod[LOSS_W-1:0];
      den_r  <= den;
      sat_r  <= num >= den;
      step_r <= '0;
    end else if (state_r == DV_STEP) begin
      rem_r  <= take ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      low_r  <= {low_r[LOSS_W-2:0], take};
      step_r <= step_r + STEP_CW'(1);
    end
  end

endmodule

`default_nettype wire
